// ----- hdl/mats_pkg.sv -----
// mats_pkg: shared constants, codes and word types of the motion action table sequencer.
// No dependencies; used by mats_table and motion_action_table_sequencer_top.
`timescale 1ns / 1ps
`default_nettype none

package mats_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // input modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;
    localparam logic [1:0] MODE_WRITE = 2'd3;

    // row action kinds
    localparam logic [2:0] K_MOVE = 3'd0;
    localparam logic [2:0] K_ROT  = 3'd1;
    localparam logic [2:0] K_WAIT = 3'd2;
    localparam logic [2:0] K_STOP = 3'd3;
    localparam logic [2:0] K_END  = 3'd4;

    // outcome codes
    localparam logic [2:0] OC_NONE    = 3'd0;
    localparam logic [2:0] OC_OK      = 3'd1;
    localparam logic [2:0] OC_INDEX   = 3'd2;
    localparam logic [2:0] OC_ACTION  = 3'd3;
    localparam logic [2:0] OC_TIMEOUT = 3'd4;
    localparam logic [2:0] OC_FAILED  = 3'd5;
    localparam logic [2:0] OC_ABORT   = 3'd6;

    // start command kinds
    localparam logic [1:0] SK_NONE = 2'd0;
    localparam logic [1:0] SK_MOVE = 2'd1;
    localparam logic [1:0] SK_SPIN = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] main;
        logic [31:0] speed;
        logic [31:0] timeout;
        logic [7:0]  next;
    } row_t;

    typedef struct packed {
        logic [1:0]  start_kind;
        logic [31:0] start_amount;
        logic [31:0] start_speed;
        logic        cancel_motion;
        logic [2:0]  run_state;
        logic [2:0]  outcome;
        logic [7:0]  current_row;
        logic        is_busy;
        logic        is_finished;
        logic        start_accepted;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/mats_table.sv -----
// mats_table: row store, one write port and one registered read port with write forwarding.
// Depends on mats_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mats_table (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [mats_pkg::ADDR_W-1:0] waddr,
    input  wire mats_pkg::row_t              wdata,
    input  wire logic [mats_pkg::ADDR_W-1:0] raddr,
    output mats_pkg::row_t                   rdata
);

    mats_pkg::row_t mem [mats_pkg::TABLE_DEPTH];
    mats_pkg::row_t rdata_reg;

    // same-address write is forwarded so the read word is never stale
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/motion_action_table_sequencer_top.sv -----
// motion_action_table_sequencer_top: table-driven motion sequencer, top level.
// Result words are registered in the output buffer; one word per cycle while in_stall is low.
// The row store read port is kept pointed at the current row, so every tick finds its row ready.
// A two-deep output buffer lets one more word in while a result waits on out_stall.
// Reset (rst_n, async, active low): idle, outcome none, row -1, tick period 10 ms.
// The row store has no reset; the user must write rows before they are read (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module motion_action_table_sequencer_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [9:0]         cfg_wdata,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         mode,
    input  wire logic [5:0]         row,
    input  wire logic [2:0]         action_kind,
    input  wire logic signed [31:0] param_main,
    input  wire logic signed [31:0] param_speed,
    input  wire logic [31:0]        row_timeout_ms,
    input  wire logic signed [7:0]  next_row,
    input  wire logic [6:0]         row_count,
    input  wire logic               motion_start_ok,
    input  wire logic               motion_busy,
    input  wire logic               motion_ok,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              start_kind,
    output logic signed [31:0]      start_amount,
    output logic signed [31:0]      start_speed,
    output logic                    cancel_motion,
    output logic [2:0]              run_state,
    output logic [2:0]              outcome,
    output logic signed [7:0]       current_row,
    output logic                    is_busy,
    output logic                    is_finished,
    output logic                    start_accepted
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_RUN  = 3'd1,
        ST_WAIT = 3'd2,
        ST_DONE = 3'd3,
        ST_ERR  = 3'd4
    } seq_state_t;

    // sequencer state
    seq_state_t  state_reg, state_next;
    logic [2:0]  outcome_reg, outcome_next;
    logic [7:0]  idx_reg, idx_next;
    logic        launched_reg, launched_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [6:0]  rows_reg;
    logic [6:0]  rows_next;
    logic [9:0]  tick_reg;

    // output buffer: head word plus one skid word
    mats_pkg::result_t out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;

    logic in_fire, out_fire;

    // row store
    mats_pkg::row_t                 wrow, cur;
    logic                           tbl_we;
    logic [mats_pkg::ADDR_W-1:0]    tbl_raddr;

    // tick datapath
    logic [7:0]  limit;
    logic        busy_now;
    logic [32:0] sum;
    logic [31:0] el_new;
    logic        failed, done, ok, cancel;
    logic [1:0]  cmd_kind;
    logic [31:0] cmd_amount, cmd_speed;
    logic        accepted;
    seq_state_t  st_t;
    logic        launched_t;
    logic [31:0] el_t;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    assign busy_now = (state_reg == ST_RUN) || (state_reg == ST_WAIT);
    assign limit    = ({1'b0, rows_reg} < 8'(mats_pkg::TABLE_DEPTH)) ? {1'b0, rows_reg}
                                                                      : 8'(mats_pkg::TABLE_DEPTH);

    assign wrow.kind    = action_kind;
    assign wrow.main    = param_main;
    assign wrow.speed   = param_speed;
    assign wrow.timeout = row_timeout_ms;
    assign wrow.next    = next_row;

    assign tbl_we    = in_fire && (mode == mats_pkg::MODE_WRITE)
                       && (32'(row) < mats_pkg::TABLE_DEPTH);
    // read port follows the row index that the next cycle will run
    assign tbl_raddr = mats_pkg::ADDR_W'(idx_next);

    mats_table u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (mats_pkg::ADDR_W'(row)),
        .wdata (wrow),
        .raddr (tbl_raddr),
        .rdata (cur)
    );

    always_comb
    begin
        state_next    = state_reg;
        outcome_next  = outcome_reg;
        idx_next      = idx_reg;
        launched_next = launched_reg;
        elapsed_next  = elapsed_reg;
        rows_next     = rows_reg;
        cancel        = 1'b0;
        accepted      = 1'b0;
        cmd_kind      = mats_pkg::SK_NONE;
        cmd_amount    = '0;
        cmd_speed     = '0;
        failed        = 1'b0;
        done          = 1'b0;
        ok            = 1'b0;
        st_t          = state_reg;
        launched_t    = launched_reg;
        el_t          = elapsed_reg;
        sum           = '0;
        el_new        = '0;

        if (in_fire)
        begin
            case (mode)
                mats_pkg::MODE_TICK:
                begin
                    if (busy_now)
                    begin
                        if (idx_reg[7] || (idx_reg >= limit))
                        begin
                            state_next    = ST_ERR;
                            outcome_next  = mats_pkg::OC_INDEX;
                            launched_next = 1'b0;
                            cancel        = 1'b1;
                        end
                        else if (cur.kind == mats_pkg::K_END)
                        begin
                            state_next    = ST_DONE;
                            outcome_next  = mats_pkg::OC_OK;
                            launched_next = 1'b0;
                            cancel        = 1'b1;
                        end
                        else
                        begin
                            // launch phase on the first tick of a row
                            if (!launched_reg)
                            begin
                                if ((cur.kind == mats_pkg::K_MOVE) || (cur.kind == mats_pkg::K_ROT))
                                begin
                                    cmd_kind   = (cur.kind == mats_pkg::K_MOVE) ? mats_pkg::SK_MOVE
                                                                                : mats_pkg::SK_SPIN;
                                    cmd_amount = cur.main;
                                    cmd_speed  = cur.speed;
                                    failed     = !motion_start_ok;
                                end
                                else if (cur.kind == mats_pkg::K_STOP)
                                begin
                                    cancel = 1'b1;
                                end
                                else if (cur.kind != mats_pkg::K_WAIT)
                                begin
                                    failed = 1'b1;
                                end
                                if (!failed)
                                begin
                                    launched_t = 1'b1;
                                    el_t       = '0;
                                    st_t       = ST_WAIT;
                                end
                            end

                            if (failed)
                            begin
                                state_next    = ST_ERR;
                                outcome_next  = mats_pkg::OC_ACTION;
                                launched_next = 1'b0;
                                cancel        = 1'b1;
                            end
                            else
                            begin
                                // saturating elapsed time
                                sum    = {1'b0, el_t} + {23'd0, tick_reg};
                                el_new = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                                elapsed_next = el_new;
                                if ((cur.timeout != '0) && (el_new > cur.timeout))
                                begin
                                    state_next    = ST_ERR;
                                    outcome_next  = mats_pkg::OC_TIMEOUT;
                                    launched_next = 1'b0;
                                    cancel        = 1'b1;
                                end
                                else
                                begin
                                    if ((cur.kind == mats_pkg::K_MOVE)
                                        || (cur.kind == mats_pkg::K_ROT))
                                    begin
                                        done = !motion_busy;
                                        ok   = motion_ok;
                                    end
                                    else if (cur.kind == mats_pkg::K_WAIT)
                                    begin
                                        done = (el_new >= cur.main);
                                        ok   = 1'b1;
                                    end
                                    else
                                    begin
                                        done = 1'b1;
                                        ok   = (cur.kind == mats_pkg::K_STOP);
                                    end

                                    if (!done)
                                    begin
                                        state_next    = st_t;
                                        launched_next = launched_t;
                                    end
                                    else if (!ok)
                                    begin
                                        state_next    = ST_ERR;
                                        outcome_next  = mats_pkg::OC_FAILED;
                                        launched_next = 1'b0;
                                        cancel        = 1'b1;
                                    end
                                    else
                                    begin
                                        launched_next = 1'b0;
                                        elapsed_next  = '0;
                                        if (cur.next[7])
                                        begin
                                            state_next   = ST_DONE;
                                            outcome_next = mats_pkg::OC_OK;
                                            cancel       = 1'b1;
                                        end
                                        else
                                        begin
                                            idx_next   = cur.next;
                                            state_next = ST_RUN;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                mats_pkg::MODE_START:
                begin
                    if ((row_count != '0) && !busy_now)
                    begin
                        rows_next     = row_count;
                        idx_next      = '0;
                        launched_next = 1'b0;
                        state_next    = ST_RUN;
                        outcome_next  = mats_pkg::OC_NONE;
                        elapsed_next  = '0;
                        accepted      = 1'b1;
                    end
                end
                mats_pkg::MODE_STOP:
                begin
                    state_next    = ST_IDLE;
                    outcome_next  = mats_pkg::OC_ABORT;
                    idx_next      = 8'hFF;
                    launched_next = 1'b0;
                    elapsed_next  = '0;
                    cancel        = 1'b1;
                end
                default:
                begin
                    // table write goes straight to the store
                end
            endcase
        end

        res.start_kind     = cmd_kind;
        res.start_amount   = cmd_amount;
        res.start_speed    = cmd_speed;
        res.cancel_motion  = cancel;
        res.run_state      = state_next;
        res.outcome        = outcome_next;
        res.current_row    = idx_next;
        res.is_busy        = (state_next == ST_RUN) || (state_next == ST_WAIT);
        res.is_finished    = (state_next == ST_DONE) || (state_next == ST_ERR);
        res.start_accepted = accepted;
    end

    // sequencer state and tick period
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            outcome_reg  <= mats_pkg::OC_NONE;
            idx_reg      <= 8'hFF;
            launched_reg <= 1'b0;
            elapsed_reg  <= '0;
            rows_reg     <= '0;
            tick_reg     <= 10'd10;
        end
        else
        begin
            state_reg    <= state_next;
            outcome_reg  <= outcome_next;
            idx_reg      <= idx_next;
            launched_reg <= launched_next;
            elapsed_reg  <= elapsed_next;
            rows_reg     <= rows_next;
            if (cfg_we)
            begin
                tick_reg <= cfg_wdata;
            end
        end
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (out_fire || !out_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (out_fire || !out_valid_reg)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign start_kind     = out_reg.start_kind;
    assign start_amount   = out_reg.start_amount;
    assign start_speed    = out_reg.start_speed;
    assign cancel_motion  = out_reg.cancel_motion;
    assign run_state      = out_reg.run_state;
    assign outcome        = out_reg.outcome;
    assign current_row    = out_reg.current_row;
    assign is_busy        = out_reg.is_busy;
    assign is_finished    = out_reg.is_finished;
    assign start_accepted = out_reg.start_accepted;

endmodule

`default_nettype wire

// ----- tb/tb_motion_action_table_sequencer_top.sv -----
// Self-checking bench for motion_action_table_sequencer_top: a directed table, then
// random table programs and runs, checked word by word against fixed values or a local predictor.
// Depends on mats_pkg and motion_action_table_sequencer_top; needs no files or arguments.
`timescale 1ns / 1ps

module tb_motion_action_table_sequencer_top;

    // run states as reported on run_state
    localparam logic [2:0] RS_IDLE = 3'd0;
    localparam logic [2:0] RS_RUN  = 3'd1;
    localparam logic [2:0] RS_WAIT = 3'd2;
    localparam logic [2:0] RS_DONE = 3'd3;
    localparam logic [2:0] RS_ERR  = 3'd4;

    localparam int HOLD_CYCLES   = 60;   // long receiver hold-off, fills the output buffer
    localparam int PHASE_WORDS   = 100;  // random words per tick-period setting
    localparam int SETTLE_CYCLES = 4;    // margin after the last owed word; the block's result words are registered

    // one input word, field by field
    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  row;
        logic [2:0]  kind;
        logic [31:0] main;
        logic [31:0] speed;
        logic [31:0] timeout;
        logic [7:0]  nxt;
        logic [6:0]  cnt;
        logic        sok;
        logic        mbusy;
        logic        mok;
    } cmd_word_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [9:0]         cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic [5:0]         row;
    logic [2:0]         action_kind;
    logic signed [31:0] param_main;
    logic signed [31:0] param_speed;
    logic [31:0]        row_timeout_ms;
    logic signed [7:0]  next_row;
    logic [6:0]         row_count;
    logic               motion_start_ok;
    logic               motion_busy;
    logic               motion_ok;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         start_kind;
    logic signed [31:0] start_amount;
    logic signed [31:0] start_speed;
    logic               cancel_motion;
    logic [2:0]         run_state;
    logic [2:0]         outcome;
    logic signed [7:0]  current_row;
    logic               is_busy;
    logic               is_finished;
    logic               start_accepted;

    motion_action_table_sequencer_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .row             (row),
        .action_kind     (action_kind),
        .param_main      (param_main),
        .param_speed     (param_speed),
        .row_timeout_ms  (row_timeout_ms),
        .next_row        (next_row),
        .row_count       (row_count),
        .motion_start_ok (motion_start_ok),
        .motion_busy     (motion_busy),
        .motion_ok       (motion_ok),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .start_kind      (start_kind),
        .start_amount    (start_amount),
        .start_speed     (start_speed),
        .cancel_motion   (cancel_motion),
        .run_state       (run_state),
        .outcome         (outcome),
        .current_row     (current_row),
        .is_busy         (is_busy),
        .is_finished     (is_finished),
        .start_accepted  (start_accepted)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: the row table plus the sequencer registers.
    // tbl_written tracks which rows hold data, so no tick ever reads junk.
    // ------------------------------------------------------------------
    logic [2:0]  tbl_kind    [mats_pkg::TABLE_DEPTH];
    logic [31:0] tbl_main    [mats_pkg::TABLE_DEPTH];
    logic [31:0] tbl_speed   [mats_pkg::TABLE_DEPTH];
    logic [31:0] tbl_timeout [mats_pkg::TABLE_DEPTH];
    logic [7:0]  tbl_next    [mats_pkg::TABLE_DEPTH];
    bit          tbl_written [mats_pkg::TABLE_DEPTH];
    logic [2:0]  seq_st   = RS_IDLE;
    logic [2:0]  seq_oc   = mats_pkg::OC_NONE;
    logic [7:0]  cur_row  = 8'hFF;
    logic        launched = 1'b0;
    logic [31:0] elapsed  = 32'd0;
    logic [6:0]  in_use   = 7'd0;
    logic [9:0]  tick_ms  = 10'd10;

    mats_pkg::result_t status_queue [$];   // result words still owed by the block
    int      mismatches = 0;
    int      words_sent = 0;
    bit      hold_req   = 1'b0;  // asks the receiver for one long hold-off
    bit      quiet      = 1'b0;  // closing stretch: no idling on either side

    function automatic bit running();
        return seq_st == RS_RUN || seq_st == RS_WAIT;
    endfunction

    // rows in use, capped by the table size
    function automatic int row_limit();
        return (int'(in_use) < mats_pkg::TABLE_DEPTH) ? int'(in_use) : mats_pkg::TABLE_DEPTH;
    endfunction

    function automatic logic abandon_run(input logic [2:0] code);
        seq_st   = RS_ERR;
        seq_oc   = code;
        launched = 1'b0;
        return 1'b1;
    endfunction

    // Applies one accepted word to the predictor state and returns the result word.
    function automatic mats_pkg::result_t sequence_step(input cmd_word_t w);
        mats_pkg::result_t r;
        logic [5:0]  i;
        logic [2:0]  k;
        logic [32:0] sum;
        logic        halt;
        logic        fin;
        logic        good;
        r = '0;
        case (w.op)
            mats_pkg::MODE_TICK:
            begin
                if (running())
                begin
                    if (cur_row[7] || int'(cur_row) >= row_limit())
                        r.cancel_motion = abandon_run(mats_pkg::OC_INDEX);
                    else
                    begin
                        i    = cur_row[5:0];
                        k    = tbl_kind[i];
                        halt = 1'b0;
                        if (k == mats_pkg::K_END)
                        begin
                            seq_st          = RS_DONE;
                            seq_oc          = mats_pkg::OC_OK;
                            launched        = 1'b0;
                            r.cancel_motion = 1'b1;
                            halt            = 1'b1;
                        end
                        else if (!launched)
                        begin
                            if (k == mats_pkg::K_MOVE || k == mats_pkg::K_ROT)
                            begin
                                // command goes out even if the controller refuses it
                                r.start_kind   = (k == mats_pkg::K_MOVE) ? mats_pkg::SK_MOVE
                                                                         : mats_pkg::SK_SPIN;
                                r.start_amount = tbl_main[i];
                                r.start_speed  = tbl_speed[i];
                                if (!w.sok)
                                begin
                                    r.cancel_motion = abandon_run(mats_pkg::OC_ACTION);
                                    halt            = 1'b1;
                                end
                            end
                            else if (k == mats_pkg::K_STOP)
                                r.cancel_motion = 1'b1;
                            else if (k != mats_pkg::K_WAIT)
                            begin
                                r.cancel_motion = abandon_run(mats_pkg::OC_ACTION);
                                halt            = 1'b1;
                            end
                            if (!halt)
                            begin
                                launched = 1'b1;
                                elapsed  = 32'd0;
                                seq_st   = RS_WAIT;
                            end
                        end
                        if (!halt)
                        begin
                            sum     = {1'b0, elapsed} + {23'd0, tick_ms};
                            elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            if (tbl_timeout[i] != 32'd0 && elapsed > tbl_timeout[i])
                                r.cancel_motion = abandon_run(mats_pkg::OC_TIMEOUT);
                            else
                            begin
                                if (k == mats_pkg::K_MOVE || k == mats_pkg::K_ROT)
                                begin
                                    fin  = !w.mbusy;
                                    good = w.mok;
                                end
                                else if (k == mats_pkg::K_WAIT)
                                begin
                                    fin  = elapsed >= tbl_main[i];
                                    good = 1'b1;
                                end
                                else
                                begin
                                    fin  = 1'b1;
                                    good = (k == mats_pkg::K_STOP);
                                end
                                if (fin && !good)
                                    r.cancel_motion = abandon_run(mats_pkg::OC_FAILED);
                                else if (fin)
                                begin
                                    launched = 1'b0;
                                    elapsed  = 32'd0;
                                    if (tbl_next[i][7])
                                    begin
                                        seq_st          = RS_DONE;
                                        seq_oc          = mats_pkg::OC_OK;
                                        r.cancel_motion = 1'b1;
                                    end
                                    else
                                    begin
                                        cur_row = tbl_next[i];
                                        seq_st  = RS_RUN;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            mats_pkg::MODE_START:
            begin
                if (w.cnt != 7'd0 && !running())
                begin
                    in_use           = w.cnt;
                    cur_row          = 8'd0;
                    launched         = 1'b0;
                    seq_st           = RS_RUN;
                    seq_oc           = mats_pkg::OC_NONE;
                    elapsed          = 32'd0;
                    r.start_accepted = 1'b1;
                end
            end
            mats_pkg::MODE_STOP:
            begin
                seq_st          = RS_IDLE;
                seq_oc          = mats_pkg::OC_ABORT;
                cur_row         = 8'hFF;
                launched        = 1'b0;
                elapsed         = 32'd0;
                r.cancel_motion = 1'b1;
            end
            default:
            begin
                tbl_kind[w.row]    = w.kind;
                tbl_main[w.row]    = w.main;
                tbl_speed[w.row]   = w.speed;
                tbl_timeout[w.row] = w.timeout;
                tbl_next[w.row]    = w.nxt;
                tbl_written[w.row] = 1'b1;
            end
        endcase
        r.run_state   = seq_st;
        r.outcome     = seq_oc;
        r.current_row = cur_row;
        r.is_busy     = running();
        r.is_finished = (seq_st == RS_DONE || seq_st == RS_ERR);
        return r;
    endfunction

    // a tick that would run a row nobody has written yet
    function automatic bit reads_unwritten(input cmd_word_t w);
        return w.op == mats_pkg::MODE_TICK && running() && !cur_row[7]
            && int'(cur_row) < row_limit() && !tbl_written[cur_row[5:0]];
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic cmd_word_t compose(
        input logic [1:0] op, input logic [5:0] r, input logic [2:0] kind,
        input logic [31:0] main, input logic [31:0] speed, input logic [31:0] timeout,
        input logic [7:0] nxt, input logic [6:0] cnt,
        input logic sok, input logic mbusy, input logic mok);
        cmd_word_t w;
        w.op = op;   w.row = r;       w.kind = kind;
        w.main = main; w.speed = speed; w.timeout = timeout;
        w.nxt = nxt; w.cnt = cnt;
        w.sok = sok; w.mbusy = mbusy; w.mok = mok;
        return w;
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        w.op      = 2'($urandom);
        w.row     = 6'($urandom);
        w.kind    = 3'($urandom);
        w.main    = $urandom;
        w.speed   = $urandom;
        w.timeout = $urandom;
        w.nxt     = 8'($urandom);
        w.cnt     = 7'($urandom);
        w.sok     = 1'($urandom);
        w.mbusy   = 1'($urandom);
        w.mok     = 1'($urandom);
        return w;
    endfunction

    // Table row write with plausible content; span is the program length.
    function automatic cmd_word_t row_word(input logic [5:0] r, input int span);
        cmd_word_t w;
        int        pick;
        w      = random_word();
        w.op   = mats_pkg::MODE_WRITE;
        w.row  = r;
        pick   = $urandom_range(0, 19);
        w.kind = pick < 5  ? mats_pkg::K_MOVE :
                 pick < 9  ? mats_pkg::K_ROT  :
                 pick < 13 ? mats_pkg::K_WAIT :
                 pick < 15 ? mats_pkg::K_STOP :
                 pick < 18 ? mats_pkg::K_END  : 3'($urandom_range(5, 7));
        if (w.kind == mats_pkg::K_WAIT && $urandom_range(0, 9) != 0)
            w.main = $urandom_range(0, 5 * int'(tick_ms));
        pick = $urandom_range(0, 9);
        w.timeout = pick < 6 ? 32'd0 :
                    pick < 9 ? 32'($urandom_range(1, 6 * int'(tick_ms))) : $urandom;
        pick = $urandom_range(0, 9);
        w.nxt = pick < 7 ? 8'(r) + 8'd1 :
                pick < 8 ? 8'($urandom_range(0, span - 1)) :
                pick < 9 ? (8'h80 | 8'($urandom)) : 8'($urandom_range(span, 127));
        return w;
    endfunction

    function automatic mats_pkg::result_t status_of(
        input logic cancel, input logic [2:0] rs, input logic [2:0] oc,
        input logic [7:0] cr, input logic acc);
        mats_pkg::result_t r;
        r                = '0;
        r.cancel_motion  = cancel;
        r.run_state      = rs;
        r.outcome        = oc;
        r.current_row    = cr;
        r.is_busy        = (rs == RS_RUN || rs == RS_WAIT);
        r.is_finished    = (rs == RS_DONE || rs == RS_ERR);
        r.start_accepted = acc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Fields change on the falling edge; a word is taken at a rising
    // edge with valid high and stall low. Fixed expectations come from the
    // directed table, otherwise the predictor supplies the result word.
    // ------------------------------------------------------------------
    task automatic send_word(input cmd_word_t w, input bit typed,
                             input mats_pkg::result_t fixed);
        mats_pkg::result_t predicted;
        int      gap;
        if (!typed && reads_unwritten(w))
            w = row_word(cur_row[5:0], row_limit());
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        mode            <= w.op;
        row             <= w.row;
        action_kind     <= w.kind;
        param_main      <= w.main;
        param_speed     <= w.speed;
        row_timeout_ms  <= w.timeout;
        next_row        <= w.nxt;
        row_count       <= w.cnt;
        motion_start_ok <= w.sok;
        motion_busy     <= w.mbusy;
        motion_ok       <= w.mok;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = sequence_step(w);
        status_queue.push_back(typed ? fixed : predicted);
        words_sent++;
    endtask

    // Drop valid and wait for every owed word, plus the block's own latency.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_tick_period(input logic [9:0] period);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= period;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tick_ms    = period;
    endtask

    // One random program: write rows 0..n-1, start it, tick it along with a
    // mix of controller answers, stray stops, starts and rewrites, then noise.
    task automatic run_program();
        cmd_word_t w;
        int        n;
        int        i;
        int        pick;
        int        budget;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
        begin
            w = row_word(6'(i), n);
            if (i == n - 1 && $urandom_range(0, 1) == 1)
            begin
                if ($urandom_range(0, 1) == 1)
                    w.kind = mats_pkg::K_END;
                else
                    w.nxt = 8'h80 | 8'($urandom);
            end
            send_word(w, 1'b0, '0);
        end
        w    = random_word();
        w.op = mats_pkg::MODE_START;
        pick = $urandom_range(0, 9);
        w.cnt = pick < 7 ? 7'(n) : pick < 9 ? 7'($urandom_range(1, 127)) : 7'd0;
        send_word(w, 1'b0, '0);
        budget = $urandom_range(4, 16);
        while (budget > 0 && running())
        begin
            pick = $urandom_range(0, 29);
            w    = random_word();
            if (pick == 0)
                w.op = mats_pkg::MODE_STOP;
            else if (pick == 1)
                w.op = mats_pkg::MODE_START;
            else if (pick == 2)
                w = row_word(6'($urandom_range(0, n - 1)), n);
            else
            begin
                w.op    = mats_pkg::MODE_TICK;
                w.sok   = $urandom_range(0, 9) != 0;
                w.mbusy = $urandom_range(0, 2) == 0;
                w.mok   = $urandom_range(0, 11) != 0;
            end
            send_word(w, 1'b0, '0);
            budget--;
        end
        // half the unfinished runs are left going into the next program
        if (running() && $urandom_range(0, 1) == 1)
        begin
            w    = random_word();
            w.op = mats_pkg::MODE_STOP;
            send_word(w, 1'b0, '0);
        end
        repeat ($urandom_range(0, 2)) send_word(random_word(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver stall: random short bursts, one long counted hold-off on
    // request, nothing in the closing stretch.
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req   = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result checking: each word taken from the block against the oldest owed one.
    always @(posedge clk)
    begin : take_result
        mats_pkg::result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (status_queue.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none got kind %h row %h",
                         $time, start_kind, current_row);
                mismatches++;
            end
            else
            begin
                want = status_queue.pop_front();
                check_field("start_kind",     want.start_kind,     start_kind);
                check_field("start_amount",   want.start_amount,   start_amount);
                check_field("start_speed",    want.start_speed,    start_speed);
                check_field("cancel_motion",  want.cancel_motion,  cancel_motion);
                check_field("run_state",      want.run_state,      run_state);
                check_field("outcome",        want.outcome,        outcome);
                check_field("current_row",    want.current_row,    $unsigned(current_row));
                check_field("is_busy",        want.is_busy,        is_busy);
                check_field("is_finished",    want.is_finished,    is_finished);
                check_field("start_accepted", want.start_accepted, start_accepted);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("** motion_action_table_sequencer_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        cmd_word_t         probe_words [$];
        bit                probe_typed [$];
        mats_pkg::result_t probe_fixed [$];
        mats_pkg::result_t fixed;
        logic [9:0]        period;
        int                i;
        int                ph;
        int                target;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 10'd0;
        in_valid        = 1'b0;
        mode            = mats_pkg::MODE_TICK;
        row             = 6'd0;
        action_kind     = mats_pkg::K_MOVE;
        param_main      = 32'sd0;
        param_speed     = 32'sd0;
        row_timeout_ms  = 32'd0;
        next_row        = 8'sd0;
        row_count       = 7'd0;
        motion_start_ok = 1'b0;
        motion_busy     = 1'b0;
        motion_ok       = 1'b0;

        // Directed table, run at the reset tick period of 10 ms.
        // Idle tick straight after reset, a refused empty start, an abort.
        probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        probe_typed.push_back(1'b1);
        probe_fixed.push_back(status_of(1'b0, RS_IDLE, mats_pkg::OC_NONE, 8'hFF, 1'b0));
        probe_words.push_back(compose(mats_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 7'd0, 1, 1, 1));
        probe_typed.push_back(1'b1);
        probe_fixed.push_back(status_of(1'b0, RS_IDLE, mats_pkg::OC_NONE, 8'hFF, 1'b0));
        probe_words.push_back(compose(mats_pkg::MODE_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        probe_typed.push_back(1'b1);
        probe_fixed.push_back(status_of(1'b1, RS_IDLE, mats_pkg::OC_ABORT, 8'hFF, 1'b0));
        // invalid kind with extreme field values, then run it
        probe_words.push_back(compose(mats_pkg::MODE_WRITE, 6'd0, 3'd7, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'hFFFF_FFFF, 8'h7F, 0, 0, 0, 0));
        probe_typed.push_back(1'b0);
        probe_fixed.push_back('0);
        probe_words.push_back(compose(mats_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 7'd1, 0, 0, 0));
        probe_typed.push_back(1'b1);
        probe_fixed.push_back(status_of(1'b0, RS_RUN, mats_pkg::OC_NONE, 8'd0, 1'b1));
        probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        probe_typed.push_back(1'b1);
        probe_fixed.push_back(status_of(1'b1, RS_ERR, mats_pkg::OC_ACTION, 8'd0, 1'b0));
        // full program: move, rotate, wait 20 ms, stop, end; plus the last row
        probe_words.push_back(compose(mats_pkg::MODE_WRITE, 6'd0, mats_pkg::K_MOVE,
                                      32'h8000_0000, 32'h7FFF_FFFF, 0, 8'd1, 0, 0, 0, 0));
        probe_words.push_back(compose(mats_pkg::MODE_WRITE, 6'd1, mats_pkg::K_ROT,
                                      32'hFFFF_FFFF, 32'd1, 0, 8'd2, 0, 0, 0, 0));
        probe_words.push_back(compose(mats_pkg::MODE_WRITE, 6'd2, mats_pkg::K_WAIT,
                                      32'd20, 0, 0, 8'd3, 0, 0, 0, 0));
        probe_words.push_back(compose(mats_pkg::MODE_WRITE, 6'd3, mats_pkg::K_STOP,
                                      0, 0, 0, 8'd4, 0, 0, 0, 0));
        probe_words.push_back(compose(mats_pkg::MODE_WRITE, 6'd4, mats_pkg::K_END,
                                      0, 0, 0, 8'h80, 0, 0, 0, 0));
        probe_words.push_back(compose(mats_pkg::MODE_WRITE, 6'd63, mats_pkg::K_END,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                                      7'h7F, 1, 1, 1));
        // rows in use beyond the table size
        probe_words.push_back(compose(mats_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 7'd127, 0, 0, 0));
        probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1));
        // start while the move is still under way: refused
        probe_words.push_back(compose(mats_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 7'd3, 0, 0, 0));
        probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        repeat (4)
            probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        for (i = 0; i < 15; i++)
        begin
            probe_typed.push_back(1'b0);
            probe_fixed.push_back('0);
        end
        // controller refuses the start: command still shown, cancel, bad action
        probe_words.push_back(compose(mats_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 7'd2, 0, 0, 0));
        probe_typed.push_back(1'b0);
        probe_fixed.push_back('0);
        fixed              = status_of(1'b1, RS_ERR, mats_pkg::OC_ACTION, 8'd0, 1'b0);
        fixed.start_kind   = mats_pkg::SK_MOVE;
        fixed.start_amount = 32'h8000_0000;
        fixed.start_speed  = 32'h7FFF_FFFF;
        probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        probe_typed.push_back(1'b1);
        probe_fixed.push_back(fixed);
        // two rows in use, second row jumps to row 2: bad index
        probe_words.push_back(compose(mats_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 7'd2, 0, 0, 0));
        probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        repeat (3) probe_typed.push_back(1'b0);
        repeat (3) probe_fixed.push_back('0);
        probe_words.push_back(compose(mats_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
        probe_typed.push_back(1'b1);
        probe_fixed.push_back(status_of(1'b1, RS_ERR, mats_pkg::OC_INDEX, 8'd2, 1'b0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < probe_words.size(); i++)
            send_word(probe_words[i], probe_typed[i], probe_fixed[i]);

        // Random phases, one tick period each: the extremes first, the long
        // hold-off in the second, and the last phase without idling.
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       period = 10'd1000;
                1:       period = 10'd1;
                2:       period = 10'($urandom_range(2, 999));
                3:       period = 10'd10;
                default: period = 10'($urandom_range(1, 1000));
            endcase
            set_tick_period(period);
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == 4)
                quiet = 1'b1;
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                run_program();
        end

        settle();
        repeat (10) @(posedge clk);
        if (status_queue.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, status_queue.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** motion_action_table_sequencer_top: PASSED **");
        else
            $display("** motion_action_table_sequencer_top: FAILED **");
        $finish;
    end

endmodule
